>>> hdl/phong_fragment_shading_assert.svh
// Assertion macros shared by the shading pipeline modules.
// Define ASSERT_OFF to compile the checks out.
`ifndef PHONG_FRAGMENT_SHADING_ASSERT_SVH
`define PHONG_FRAGMENT_SHADING_ASSERT_SVH
`ifndef ASSERT_OFF
`define PFS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PFS_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define PFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> hdl/pfs_pkg.sv
// Shared types and constants of the Phong fragment shading pipeline.
// No dependencies.
`default_nettype none
package pfs_pkg;

   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int SPEC_EXP   = 30;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_X    = 3'd0,
      CSR_LIGHT_Y    = 3'd1,
      CSR_LIGHT_Z    = 3'd2,
      CSR_BASE_CHAN0 = 3'd3,
      CSR_BASE_CHAN1 = 3'd4,
      CSR_BASE_CHAN2 = 3'd5,
      CSR_AMBIENT    = 3'd6,
      CSR_DIFF_GAIN  = 3'd7
   } csr_index_type;

   localparam logic [15:0] LIGHT_RESET   = 16'd9459;
   localparam logic [7:0]  BASE0_RESET   = 8'd150;
   localparam logic [7:0]  BASE1_RESET   = 8'd100;
   localparam logic [7:0]  BASE2_RESET   = 8'd244;
   localparam logic [14:0] AMBIENT_RESET = 15'd4915;
   localparam logic [14:0] GAIN_RESET    = 15'd6554;

endpackage
`default_nettype wire

>>> hdl/phong_fragment_shading.sv
// Phong fragment shading pipeline, top level.
// Depends on pfs_pkg, pfs_sqrt_pipe, pfs_div_pipe and the assertion header.
//
// Usage:
//  - Request channel (req_*): one fragment per request, three barycentric
//    weights and three vertex normals, all signed fixed point.
//  - Response channel (rsp_*): one shaded color (three 8-bit channels) per
//    request, in request order.
//  - CSR channel (csr_*): light direction, base color, ambient level and
//    diffuse gain; csr_ready is always high. Write only while no request
//    is in flight.
//  - Throughput: one request per cycle while the response is not stalled.
//    The pipeline depth is set by the square root (one root bit per
//    stage), the divider (one quotient bit per stage) and the 29
//    multiplies of the specular power chain.
//  - Reset: all stages empty, CSRs return to their default values.
//  - Stall: while rsp_valid is high and rsp_stall is high, the whole
//    pipeline holds and req_stall is raised; nothing is dropped.
`default_nettype none
`include "phong_fragment_shading_assert.svh"
module phong_fragment_shading #(
   parameter int FRAC_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [15:0]                  req_bary_a,
   input  logic signed [15:0]                  req_bary_b,
   input  logic signed [15:0]                  req_bary_c,
   input  logic signed [15:0]                  req_na_x,
   input  logic signed [15:0]                  req_na_y,
   input  logic signed [15:0]                  req_na_z,
   input  logic signed [15:0]                  req_nb_x,
   input  logic signed [15:0]                  req_nb_y,
   input  logic signed [15:0]                  req_nb_z,
   input  logic signed [15:0]                  req_nc_x,
   input  logic signed [15:0]                  req_nc_y,
   input  logic signed [15:0]                  req_nc_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_chan0,
   output logic [7:0]                          rsp_out_chan1,
   output logic [7:0]                          rsp_out_chan2,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pfs_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pfs_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int ONE  = 1 << F;
   localparam int MW   = 33 - F;        // interpolated normal component
   localparam int SQW  = 2 * MW;        // squared length
   localparam int QW   = F + 1;         // normalized magnitude
   localparam int NNW  = F + 2;         // signed normalized component
   localparam int DPW  = F + 18;
   localparam int DSW  = F + 20;
   localparam int DW   = 20;            // dot product
   localparam int RPW  = F + 22;
   localparam int RZW  = F + 24;
   localparam int GDW  = 34 - F;
   localparam int IW   = F + 1;         // intensity
   localparam int SUMW = F + 22;
   localparam int SE   = SPEC_EXP;

   // ---------------- CSRs ----------------
   logic signed [15:0] light_x_ff, light_y_ff, light_z_ff;
   logic [7:0]         base_ff [3];
   logic [14:0]        ambient_ff, gain_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_x_ff <= LIGHT_RESET;
         light_y_ff <= LIGHT_RESET;
         light_z_ff <= LIGHT_RESET;
         base_ff[0] <= BASE0_RESET;
         base_ff[1] <= BASE1_RESET;
         base_ff[2] <= BASE2_RESET;
         ambient_ff <= AMBIENT_RESET;
         gain_ff    <= GAIN_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LIGHT_X:    light_x_ff <= csr_data;
            CSR_LIGHT_Y:    light_y_ff <= csr_data;
            CSR_LIGHT_Z:    light_z_ff <= csr_data;
            CSR_BASE_CHAN0: base_ff[0] <= csr_data[7:0];
            CSR_BASE_CHAN1: base_ff[1] <= csr_data[7:0];
            CSR_BASE_CHAN2: base_ff[2] <= csr_data[7:0];
            CSR_AMBIENT:    ambient_ff <= csr_data[14:0];
            CSR_DIFF_GAIN:  gain_ff    <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipeline control ----------------
   // One global enable: hold every stage while the response is stalled.
   logic         advance;
   pipe_ctl_type sqrt_ctl, div_ctl;

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------- S1: barycentric products ----------------
   logic signed [15:0] bary_w [3];
   logic signed [15:0] nrm_w  [3][3];   // [vertex][axis]
   logic signed [31:0] prod_ff [3][3];  // [axis][vertex]
   logic               s1_vld_ff;

   assign bary_w = '{req_bary_a, req_bary_b, req_bary_c};
   assign nrm_w  = '{'{req_na_x, req_na_y, req_na_z},
                     '{req_nb_x, req_nb_y, req_nb_z},
                     '{req_nc_x, req_nc_y, req_nc_z}};

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++)
               prod_ff[i][k] <= bary_w[k] * nrm_w[k][i];
      end
   end

   // ---------------- S2: interpolated normal ----------------
   logic signed [32:0]   acc_w [3];
   logic signed [MW-1:0] m2_ff [3];
   logic                 s2_vld_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc_w[i] = prod_ff[i][0];
         acc_w[i] = acc_w[i] + prod_ff[i][1] + prod_ff[i][2];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) m2_ff[i] <= MW'(acc_w[i] >>> F);
      end
   end

   // ---------------- S3: squares ----------------
   logic signed [SQW-1:0] msq_w  [3];
   logic [SQW-1:0]        msq_ff [3];
   logic signed [MW-1:0]  m3_ff  [3];
   logic                  s3_vld_ff;
   logic [SQW-1:0]        sq_sum_w;

   always_comb begin
      for (int i = 0; i < 3; i++) msq_w[i] = m2_ff[i] * m2_ff[i];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            msq_ff[i] <= msq_w[i];
            m3_ff[i]  <= m2_ff[i];
         end
      end
   end

   assign sq_sum_w = msq_ff[0] + msq_ff[1] + msq_ff[2];

   // ---------------- length: square root ----------------
   logic              sqrt_vld_w;
   logic [MW-1:0]     len_w;
   logic [3*MW-1:0]   sqrt_side_w;

   assign sqrt_ctl = '{advance: advance, valid: s3_vld_ff};

   pfs_sqrt_pipe #(.RAD_W(SQW), .SIDE_W(3*MW)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sqrt_ctl),
      .rad_in   (sq_sum_w),
      .side_in  ({m3_ff[2], m3_ff[1], m3_ff[0]}),
      .vld_out  (sqrt_vld_w),
      .root_out (len_w),
      .side_out (sqrt_side_w)
   );

   // ---------------- normalize: divide magnitudes by the length ----------------
   logic [2:0][MW-1:0] num_w;
   logic [2:0]         sign_w;
   logic               div_vld_w;
   logic [2:0][QW-1:0] quo_w;
   logic [3:0]         div_side_w;

   always_comb begin
      logic signed [MW-1:0] mv;
      for (int i = 0; i < 3; i++) begin
         mv        = sqrt_side_w[i*MW +: MW];
         sign_w[i] = mv[MW-1];
         num_w[i]  = mv[MW-1] ? MW'(-mv) : MW'(mv);
      end
   end

   assign div_ctl = '{advance: advance, valid: sqrt_vld_w};

   pfs_div_pipe #(.NW(MW), .QW(QW), .SIDE_W(4)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .num_in   (num_w),
      .den_in   (len_w),
      .side_in  ({sign_w, (len_w == '0)}),
      .vld_out  (div_vld_w),
      .quo_out  (quo_w),
      .side_out (div_side_w)
   );

   // ---------------- S5: restore signs ----------------
   logic signed [NNW-1:0] n_ff [3];
   logic                  s5_zero_ff, s5_vld_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++)
            n_ff[i] <= div_side_w[i+1] ? -$signed({1'b0, quo_w[i]})
                                       :  $signed({1'b0, quo_w[i]});
         s5_zero_ff <= div_side_w[0];
      end
   end

   // ---------------- S6: n times l ----------------
   logic signed [15:0]    light_w [3];
   logic signed [DPW-1:0] dp_w  [3];
   logic signed [DPW-1:0] dp_ff [3];
   logic signed [NNW-1:0] nz6_ff;
   logic                  zero6_ff, vld6_ff;

   assign light_w = '{light_x_ff, light_y_ff, light_z_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) dp_w[i] = n_ff[i] * light_w[i];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dp_ff    <= dp_w;
         nz6_ff   <= n_ff[2];
         zero6_ff <= s5_zero_ff;
      end
   end

   // ---------------- S7: dot product ----------------
   logic signed [DSW-1:0] dsum_w;
   logic signed [DW-1:0]  dot_ff;
   logic signed [NNW-1:0] nz7_ff;
   logic                  zero7_ff, vld7_ff;

   always_comb begin
      dsum_w = dp_ff[0];
      dsum_w = dsum_w + dp_ff[1] + dp_ff[2];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dot_ff   <= DW'(dsum_w >>> F);
         nz7_ff   <= nz6_ff;
         zero7_ff <= zero6_ff;
      end
   end

   // ---------------- S8: reflection product, diffuse clamp ----------------
   logic signed [RPW-1:0] rzp_w;
   logic signed [RPW-1:0] rzp_ff;
   logic [DW-2:0]         diff_ff;
   logic                  zero8_ff, vld8_ff;

   assign rzp_w = nz7_ff * dot_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rzp_ff   <= rzp_w;
         diff_ff  <= dot_ff[DW-1] ? '0 : dot_ff[DW-2:0];
         zero8_ff <= zero7_ff;
      end
   end

   // ---------------- S9 + specular power chain ----------------
   // r.z = asr(2 * n.z * dot, F) - l.z, clamp to [0, ONE].
   logic signed [RZW-1:0] rzs_w, rz_w;
   logic                  rz_sat_w;
   logic [F-1:0]          rz_x_w;
   logic [33:0]           gd_prod_w;

   logic [F-1:0]   x_ch_ff    [0:SE-1];
   logic [F-1:0]   p_ch_ff    [0:SE-1];
   logic           sat_ch_ff  [0:SE-1];
   logic [GDW-1:0] gd_ch_ff   [0:SE-1];
   logic           zero_ch_ff [0:SE-1];
   logic           vld_ch_ff  [0:SE-1];
   logic [2*F-1:0] cp_w       [0:SE-2];

   always_comb begin
      rzs_w    = rzp_ff >>> (F - 1);
      rz_w     = rzs_w - light_z_ff;
      rz_sat_w = !rz_w[RZW-1] && (rz_w >= RZW'(ONE));
      rz_x_w   = rz_w[RZW-1] ? '0 : rz_w[F-1:0];
      gd_prod_w = gain_ff * diff_ff;
      for (int j = 0; j < SE-1; j++) cp_w[j] = p_ch_ff[j] * x_ch_ff[j];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ch_ff[0]    <= rz_x_w;
         p_ch_ff[0]    <= rz_x_w;
         sat_ch_ff[0]  <= rz_sat_w;
         gd_ch_ff[0]   <= gd_prod_w[33:F];
         zero_ch_ff[0] <= zero8_ff;
         for (int j = 1; j < SE; j++) begin
            x_ch_ff[j]    <= x_ch_ff[j-1];
            p_ch_ff[j]    <= cp_w[j-1][2*F-1:F];
            sat_ch_ff[j]  <= sat_ch_ff[j-1];
            gd_ch_ff[j]   <= gd_ch_ff[j-1];
            zero_ch_ff[j] <= zero_ch_ff[j-1];
         end
      end
   end

   // ---------------- S10: intensity ----------------
   logic [IW-1:0]   spec_w;
   logic [SUMW-1:0] isum_w;
   logic [IW-1:0]   int_ff;
   logic            int_vld_ff;

   always_comb begin
      spec_w = sat_ch_ff[SE-1] ? IW'(ONE) : {1'b0, p_ch_ff[SE-1]};
      if (zero_ch_ff[SE-1]) begin
         // zero-length normal: ambient only
         isum_w = SUMW'(ambient_ff);
      end else begin
         isum_w = SUMW'(ambient_ff) + SUMW'(gd_ch_ff[SE-1]) + SUMW'(spec_w);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         int_ff <= (isum_w > SUMW'(ONE)) ? IW'(ONE) : isum_w[IW-1:0];
      end
   end

   // ---------------- S11: color scale, response register ----------------
   logic [F+8:0] col_w [3];
   logic [7:0]   out_ff [3];
   logic         rsp_vld_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) col_w[k] = base_ff[k] * int_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) out_ff[k] <= col_w[k][F+7:F];
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_out_chan0 = out_ff[0];
   assign rsp_out_chan1 = out_ff[1];
   assign rsp_out_chan2 = out_ff[2];

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         vld6_ff    <= 1'b0;
         vld7_ff    <= 1'b0;
         vld8_ff    <= 1'b0;
         for (int j = 0; j < SE; j++) vld_ch_ff[j] <= 1'b0;
         int_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff    <= req_valid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s5_vld_ff    <= div_vld_w;
         vld6_ff      <= s5_vld_ff;
         vld7_ff      <= vld6_ff;
         vld8_ff      <= vld7_ff;
         vld_ch_ff[0] <= vld8_ff;
         for (int j = 1; j < SE; j++) vld_ch_ff[j] <= vld_ch_ff[j-1];
         int_vld_ff   <= vld_ch_ff[SE-1];
         rsp_vld_ff   <= int_vld_ff;
      end
   end

   // ---------------- assertions ----------------
   `PFS_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && !req_stall, s1_vld_ff, "accepted request missing from first stage")
   `PFS_ASSERT_IMPL(a_norm_bounded, clock, reset, s5_vld_ff && !s5_zero_ff, (n_ff[0] <= NNW'(ONE)) && (n_ff[1] <= NNW'(ONE)) && (n_ff[2] <= NNW'(ONE)), "normalized component above one")
   `PFS_ASSERT_IMPL(a_intensity_sat, clock, reset, int_vld_ff, int_ff <= IW'(ONE), "intensity not saturated at one")

endmodule
`default_nettype wire

>>> hdl/pfs_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with side data.
// Depends on pfs_pkg for the pipeline control struct.
`default_nettype none
module pfs_sqrt_pipe #(
   parameter int RAD_W  = 38,
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pfs_pkg::pipe_ctl_type ctl,
   input  logic [RAD_W-1:0]      rad_in,
   input  logic [SIDE_W-1:0]     side_in,
   output logic                  vld_out,
   output logic [RAD_W/2-1:0]    root_out,
   output logic [SIDE_W-1:0]     side_out
);
   localparam int LW   = RAD_W / 2;
   localparam int REMW = LW + 3;

   logic [REMW-1:0]   rem_ff  [0:LW];
   logic [LW-1:0]     root_ff [0:LW];
   logic [RAD_W-1:0]  rad_ff  [0:LW];
   logic [SIDE_W-1:0] side_ff [0:LW];
   logic              vld_ff  [0:LW];
   logic [REMW-1:0]   rem_in  [1:LW];
   logic [LW-1:0]     root_in [1:LW];

   always_comb begin
      logic [REMW-1:0] rem_sh;
      logic [REMW-1:0] trial;
      for (int k = 1; k <= LW; k++) begin
         rem_sh = {rem_ff[k-1][REMW-3:0], rad_ff[k-1][RAD_W-1-2*(k-1) -: 2]};
         trial  = REMW'({root_ff[k-1], 2'b01});
         if (rem_sh >= trial) begin
            rem_in[k]  = rem_sh - trial;
            root_in[k] = {root_ff[k-1][LW-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh;
            root_in[k] = {root_ff[k-1][LW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= LW; k++) vld_ff[k] <= 1'b0;
      end else if (ctl.advance) begin
         vld_ff[0] <= ctl.valid;
         for (int k = 1; k <= LW; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         rad_ff[0]  <= rad_in;
         side_ff[0] <= side_in;
         for (int k = 1; k <= LW; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign vld_out  = vld_ff[LW];
   assign root_out = root_ff[LW];
   assign side_out = side_ff[LW];
endmodule
`default_nettype wire

>>> hdl/pfs_div_pipe.sv
// Pipelined three-lane fraction divider: quotient of num * 2^(QW-1) / den,
// one quotient bit per stage, for num <= den. Depends on pfs_pkg.
`default_nettype none
module pfs_div_pipe #(
   parameter int NW     = 19,
   parameter int QW     = 15,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pfs_pkg::pipe_ctl_type  ctl,
   input  logic [2:0][NW-1:0]     num_in,
   input  logic [NW-1:0]          den_in,
   input  logic [SIDE_W-1:0]      side_in,
   output logic                   vld_out,
   output logic [2:0][QW-1:0]     quo_out,
   output logic [SIDE_W-1:0]      side_out
);
   logic [2:0][NW:0]   rem_ff  [0:QW];
   logic [2:0][QW-1:0] q_ff    [0:QW];
   logic [NW-1:0]      den_ff  [0:QW];
   logic [SIDE_W-1:0]  side_ff [0:QW];
   logic               vld_ff  [0:QW];
   logic [2:0][NW:0]   rem_in  [1:QW];
   logic [2:0][QW-1:0] q_in    [1:QW];

   always_comb begin
      logic [NW:0] shifted;
      logic        ge;
      for (int j = 1; j <= QW; j++) begin
         for (int i = 0; i < 3; i++) begin
            shifted = (j == 1) ? rem_ff[j-1][i] : {rem_ff[j-1][i][NW-1:0], 1'b0};
            ge      = shifted >= {1'b0, den_ff[j-1]};
            rem_in[j][i] = ge ? shifted - {1'b0, den_ff[j-1]} : shifted;
            q_in[j][i]   = {q_ff[j-1][i][QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QW; j++) vld_ff[j] <= 1'b0;
      end else if (ctl.advance) begin
         vld_ff[0] <= ctl.valid;
         for (int j = 1; j <= QW; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int i = 0; i < 3; i++) rem_ff[0][i] <= {1'b0, num_in[i]};
         q_ff[0]    <= '0;
         den_ff[0]  <= den_in;
         side_ff[0] <= side_in;
         for (int j = 1; j <= QW; j++) begin
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
            den_ff[j]  <= den_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign vld_out  = vld_ff[QW];
   assign quo_out  = q_ff[QW];
   assign side_out = side_ff[QW];
endmodule
`default_nettype wire

>>> test/phong_fragment_shading_test.sv
// Self-checking testbench for the Phong fragment shading pipeline.
// Depends on pfs_pkg and phong_fragment_shading; predicts every shaded color in
// a scoreboard class and compares each response field by field.
`timescale 1ns / 100ps
module phong_fragment_shading_test;
   import pfs_pkg::*;

   localparam int FRAC = 14;
   localparam longint ONE = 64'sd1 << FRAC;
   localparam int LATENCY = 75;

   typedef struct {
      logic signed [15:0] bary [3];
      logic signed [15:0] nrm [3][3];   // [vertex][axis]
   } fragment_type;

   typedef struct {
      logic [7:0] chan [3];
   } color_type;

   // Predict each shaded color from its own copy of the CSRs.
   class shade_scoreboard;
      logic signed [15:0] light [3];
      logic [7:0]  base [3];
      logic [14:0] ambient;
      logic [14:0] gain;
      color_type   pending [$];
      int          errors;

      function void reset_csrs();
         light = '{16'sd9459, 16'sd9459, 16'sd9459};
         base = '{8'd150, 8'd100, 8'd244};
         ambient = 15'd4915;
         gain = 15'd6554;
      endfunction

      function void write_csr(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_LIGHT_X: light[0] = data;
            CSR_LIGHT_Y: light[1] = data;
            CSR_LIGHT_Z: light[2] = data;
            CSR_BASE_CHAN0: base[0] = data[7:0];
            CSR_BASE_CHAN1: base[1] = data[7:0];
            CSR_BASE_CHAN2: base[2] = data[7:0];
            CSR_AMBIENT: ambient = data[14:0];
            CSR_DIFF_GAIN: gain = data[14:0];
            default: ;
         endcase
      endfunction

      static function longint unsigned root_floor(longint unsigned v);
         longint unsigned res, bit_w;
         res = 0;
         bit_w = 64'd1 << 62;
         while (bit_w > v) bit_w >>= 2;
         while (bit_w != 0) begin
            if (v >= res + bit_w) begin
               v -= res + bit_w;
               res = (res >> 1) + bit_w;
            end else begin
               res >>= 1;
            end
            bit_w >>= 2;
         end
         return root_floor_ret(res);
      endfunction

      static function longint unsigned root_floor_ret(longint unsigned r);
         return r;
      endfunction

      function void note_fragment(fragment_type f);
         longint m [3], n [3], acc, dot, diffuse, rz, spec, inten;
         longint unsigned sq, len;
         color_type c;
         sq = 0;
         for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
               acc += longint'(f.bary[k]) * longint'(f.nrm[k][i]);
            m[i] = acc >>> FRAC;   // arithmetic shift rounds toward minus infinity
            sq += longint'(m[i] * m[i]);
         end
         len = root_floor(sq);
         if (len == 0) begin
            inten = ambient;
         end else begin
            dot = 0;
            for (int i = 0; i < 3; i++) n[i] = (m[i] * ONE) / longint'(len);
            for (int i = 0; i < 3; i++) dot += n[i] * longint'(light[i]);
            dot = dot >>> FRAC;
            diffuse = dot > 0 ? dot : 0;
            rz = ((2 * n[2] * dot) >>> FRAC) - longint'(light[2]);
            if (rz < 0) rz = 0;
            if (rz >= ONE) begin
               spec = ONE;
            end else begin
               spec = rz;
               for (int k = 1; k < SPEC_EXP; k++) spec = (spec * rz) >> FRAC;
            end
            inten = longint'(ambient) + ((longint'(gain) * diffuse) >> FRAC) + spec;
         end
         if (inten > ONE) inten = ONE;
         for (int i = 0; i < 3; i++) c.chan[i] = 8'((longint'(base[i]) * inten) >> FRAC);
         pending.push_back(c);
      endfunction

      function void check_color(logic [7:0] got [3]);
         color_type exp_c;
         if (pending.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         exp_c = pending.pop_front();
         for (int i = 0; i < 3; i++)
            if (got[i] !== exp_c.chan[i]) begin
               $error("out_chan%0d mismatch: expected %0d, actual %0d", i, exp_c.chan[i], got[i]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_bary_a = '0, req_bary_b = '0, req_bary_c = '0;
   logic signed [15:0] req_na_x = '0, req_na_y = '0, req_na_z = '0;
   logic signed [15:0] req_nb_x = '0, req_nb_y = '0, req_nb_z = '0;
   logic signed [15:0] req_nc_x = '0, req_nc_y = '0, req_nc_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_chan0, rsp_out_chan1, rsp_out_chan2;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   shade_scoreboard board = new();

   // Stall control: random bursts, a long hold-off on request, none in the tail.
   bit quiet_tail = 0;
   bit hold_req = 0;    // toggled by the stimulus to ask for a long hold
   bit hold_ack = 0;    // follows hold_req once the receiver takes the request
   bit hold_long = 0;
   int hold_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   phong_fragment_shading dut (.*);

   // Check every accepted response at the edge that takes it.
   always @(posedge clock) begin
      logic [7:0] got [3];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_chan0, rsp_out_chan1, rsp_out_chan2};
         board.check_color(got);
      end
   end

   // Receiver: random stall bursts, or a long counted hold.
   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         hold_long <= 1;
         hold_cycles <= 149;
         rsp_stall <= 1'b1;
      end else if (hold_long) begin
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
         end else begin
            rsp_stall <= 1'b0;
            hold_long <= 0;
         end
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         if (hold_cycles == 1) rsp_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= $urandom_range(1, 3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         3: return 16'sd16384;
         4: return -16'sd16384;
         default: return 16'($urandom);
      endcase
   endfunction

   // Plausible fragment: weights near a partition of one, unit-ish normals.
   function automatic fragment_type make_fragment(bit wild);
      fragment_type f;
      int wa, wb;
      if (wild) begin
         for (int k = 0; k < 3; k++) begin
            f.bary[k] = pick_value();
            for (int i = 0; i < 3; i++) f.nrm[k][i] = pick_value();
         end
      end else begin
         wa = $urandom_range(0, 16384);
         wb = $urandom_range(0, 16384 - wa);
         f.bary = '{16'(wa), 16'(wb), 16'(16384 - wa - wb)};
         for (int k = 0; k < 3; k++)
            for (int i = 0; i < 3; i++)
               f.nrm[k][i] = 16'(int'($urandom_range(0, 32768)) - 16384);
      end
      return f;
   endfunction

   // Offer one request and hold it until the block takes it.
   task automatic send_fragment(fragment_type f);
      req_valid <= 1'b1;
      {req_bary_a, req_bary_b, req_bary_c} <= {f.bary[0], f.bary[1], f.bary[2]};
      {req_na_x, req_na_y, req_na_z} <= {f.nrm[0][0], f.nrm[0][1], f.nrm[0][2]};
      {req_nb_x, req_nb_y, req_nb_z} <= {f.nrm[1][0], f.nrm[1][1], f.nrm[1][2]};
      {req_nc_x, req_nc_y, req_nc_z} <= {f.nrm[2][0], f.nrm[2][1], f.nrm[2][2]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_fragment(f);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_csr(idx, data);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(int count);
      for (int j = 0; j < count; j++) send_fragment(make_fragment($urandom_range(0, 4) == 0));
   endtask

   initial begin
      fragment_type f;
      board.reset_csrs();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero-length normal, extremes, axis-aligned normals.
      f = make_fragment(0);
      f.bary = '{16'sd0, 16'sd0, 16'sd0};
      send_fragment(f);
      for (int v = 0; v < 6; v++) begin
         f.bary = '{16'sd16384, 16'sd0, 16'sd0};
         f.nrm[0] = '{16'sd0, 16'sd0, 16'sd0};
         f.nrm[0][v % 3] = (v < 3) ? 16'sd16384 : -16'sd16384;
         send_fragment(f);
      end
      f.bary = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      f.nrm = '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF},
                '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}};
      send_fragment(f);
      f.bary = '{16'sh8000, 16'sh8000, 16'sh8000};
      f.nrm = '{'{16'sh8000, 16'sh8000, 16'sh8000}, '{16'sh8000, 16'sh8000, 16'sh8000},
                '{16'sh8000, 16'sh8000, 16'sh8000}};
      send_fragment(f);
      f.bary = '{16'sh7FFF, 16'sh8000, 16'sd1};
      f.nrm = '{'{16'sh8000, 16'sh7FFF, 16'sh8000}, '{16'sh7FFF, 16'sh8000, 16'sh7FFF},
                '{-16'sd1, 16'sd1, -16'sd1}};
      send_fragment(f);
      run_random(200);

      // Long receiver hold-off while requests keep coming, to fill the pipe.
      hold_req <= !hold_req;
      run_random(200);
      drain();
      repeat (LATENCY + 5) @(posedge clock);

      // Light straight at the viewer, saturating ambient, extreme color.
      write_csr(CSR_LIGHT_X, 16'd0);
      write_csr(CSR_LIGHT_Y, 16'd0);
      write_csr(CSR_LIGHT_Z, 16'd16384);
      write_csr(CSR_BASE_CHAN0, 16'd255);
      write_csr(CSR_BASE_CHAN1, 16'd0);
      write_csr(CSR_BASE_CHAN2, 16'hFF80);
      write_csr(CSR_AMBIENT, 16'h7FFF);
      write_csr(CSR_DIFF_GAIN, 16'd0);
      f.bary = '{16'sd0, 16'sd0, 16'sd0};
      send_fragment(f);
      run_random(200);
      drain();

      // Unnormalized light at the range limits, full gain, no ambient.
      write_csr(CSR_LIGHT_X, 16'h8000);
      write_csr(CSR_LIGHT_Y, 16'h7FFF);
      write_csr(CSR_LIGHT_Z, 16'h8000);
      write_csr(CSR_AMBIENT, 16'd0);
      write_csr(CSR_DIFF_GAIN, 16'h7FFF);
      write_csr(CSR_BASE_CHAN1, 16'd200);
      run_random(250);
      drain();

      // Random settings, light at minus z to reach strong specular.
      write_csr(CSR_LIGHT_X, 16'($urandom_range(0, 4000)));
      write_csr(CSR_LIGHT_Y, 16'($urandom));
      write_csr(CSR_LIGHT_Z, -16'sd16384);
      write_csr(CSR_AMBIENT, 16'd16384);
      write_csr(CSR_DIFF_GAIN, 16'($urandom));
      write_csr(CSR_BASE_CHAN0, 16'($urandom));
      run_random(250);

      // Tail with no idling on either side.
      quiet_tail = 1;
      run_random(300);
      drain();
      repeat (LATENCY + 10) @(posedge clock);

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/pfs_pkg.sv
hdl/pfs_sqrt_pipe.sv
hdl/pfs_div_pipe.sv
hdl/phong_fragment_shading.sv
test/phong_fragment_shading_test.sv
